>>> rtl/pbhm_pkg.sv
// pbhm_pkg: shared types, constants and band tables of the power band health monitor
// no dependencies; used by every rtl file through scoped names
package pbhm_pkg;

  localparam int POS_W      = 4;
  localparam int RAW_W      = 16;
  localparam int POWER_W    = 23;
  localparam int STREAK_W   = 16;
  localparam int SETTLE_W   = 8;
  localparam int NUM_POSITIONS = 16;

  // divide by 50 and by 20 as reciprocal multiplies, exact over 16-bit inputs
  localparam int CUR_RECIP_W  = 17;
  localparam int VOLT_RECIP_W = 16;
  localparam logic [CUR_RECIP_W-1:0]  CUR_RECIP  = 17'd83887;
  localparam logic [VOLT_RECIP_W-1:0] VOLT_RECIP = 16'd52429;
  localparam int CUR_SHIFT  = 22;
  localparam int VOLT_SHIFT = 20;
  localparam int CURQ_W     = 11;
  localparam int VOLTQ_W    = 12;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIATION_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_AFTER     = 2'd2;

  localparam logic [SETTLE_W-1:0] SETTLE_COUNT_RST    = 8'd5;
  localparam logic [POWER_W-1:0]  VARIATION_LIMIT_RST = 23'd20;
  localparam logic [STREAK_W-1:0] FIXED_AFTER_RST     = 16'd400;

  localparam logic [SETTLE_W-1:0] SETTLE_MAX = 8'hFF;
  localparam logic [STREAK_W-1:0] STREAK_MAX = 16'hFFFF;

  // position condition and sample class codes
  localparam logic [1:0] ST_WHITE  = 2'd0;
  localparam logic [1:0] ST_GREEN  = 2'd1;
  localparam logic [1:0] ST_YELLOW = 2'd2;
  localparam logic [1:0] ST_RED    = 2'd3;

  // bands: inclusive low, exclusive high
  localparam int BAND_W = 11;
  localparam logic [BAND_W-1:0] GREEN_LO [NUM_POSITIONS] = '{
    11'd0, 11'd41, 11'd101, 11'd191, 11'd266, 11'd351, 11'd426, 11'd521,
    11'd631, 11'd751, 11'd881, 11'd1001, 11'd1161, 11'd1321, 11'd1531, 11'd1751};
  localparam logic [BAND_W-1:0] GREEN_HI [NUM_POSITIONS] = '{
    11'd1, 11'd110, 11'd260, 11'd340, 11'd470, 11'd620, 11'd800, 11'd870,
    11'd1020, 11'd1140, 11'd1250, 11'd1370, 11'd1470, 11'd1550, 11'd1670, 11'd1800};
  localparam logic [BAND_W-1:0] YELLOW_LO [NUM_POSITIONS] = '{
    11'd0, 11'd41, 11'd101, 11'd191, 11'd266, 11'd351, 11'd426, 11'd521,
    11'd631, 11'd751, 11'd881, 11'd1001, 11'd1161, 11'd1321, 11'd1531, 11'd1751};
  localparam logic [BAND_W-1:0] YELLOW_HI [NUM_POSITIONS] = '{
    11'd1, 11'd110, 11'd260, 11'd340, 11'd470, 11'd620, 11'd800, 11'd870,
    11'd1020, 11'd1140, 11'd1250, 11'd1370, 11'd1470, 11'd1550, 11'd1670, 11'd1800};

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [RAW_W-1:0] current;
    logic [RAW_W-1:0] voltage;
  } in_item_t;

  typedef struct packed {
    logic [POWER_W-1:0]  power;
    logic                judged;
    logic [1:0]          sample_class;
    logic [1:0]          position_state;
    logic [STREAK_W-1:0] green_count;
    logic [STREAK_W-1:0] yellow_count;
  } out_item_t;

  // item handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [POWER_W-1:0] power;
  } work_item_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_count;
    logic [POWER_W-1:0]  variation_limit;
    logic [STREAK_W-1:0] fixed_after;
  } cfg_t;

endpackage

>>> rtl/power_band_health_monitor_unit.sv
// power_band_health_monitor_unit: top level, configuration registers and block wiring
// depends on pbhm_pkg, pbhm_front, pbhm_queue, pbhm_back
//
// Takes one sample item per clock while in_stall is low and returns one result item per
// sample, in order. A sample enters a two-stage front (divides by constants as reciprocal
// multiplies, then the power multiply), waits in a short queue, and is applied in the back,
// where the window write, the spread test, the band check and the read-modify-write of that
// position's state and streaks all happen in the same cycle; that state update sets the
// sustained rate of one item per cycle while the output is not stalled. A sample passes the
// stage-one and stage-two registers, the queue and the output register, so new samples keep
// flowing into the front and queue while a result waits. Configuration writes are always ready
// and should only be issued while the block is idle.
module power_band_health_monitor_unit #(
  parameter int WINDOW_DEPTH = 4,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pbhm_pkg::in_item_t                  in_data,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output pbhm_pkg::out_item_t                 out_data,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbhm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbhm_pkg::POWER_W-1:0]        cfg_data
);

  pbhm_pkg::cfg_t       cfg_r;
  logic                 q_push;
  pbhm_pkg::work_item_t q_push_data;
  logic                 q_full;
  logic                 q_pop;
  pbhm_pkg::work_item_t q_pop_data;
  logic                 q_empty;

  // writes are taken every cycle
  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_count    <= pbhm_pkg::SETTLE_COUNT_RST;
      cfg_r.variation_limit <= pbhm_pkg::VARIATION_LIMIT_RST;
      cfg_r.fixed_after     <= pbhm_pkg::FIXED_AFTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbhm_pkg::CFG_SETTLE_COUNT: begin
          cfg_r.settle_count <= cfg_data[pbhm_pkg::SETTLE_W-1:0];
        end
        pbhm_pkg::CFG_VARIATION_LIMIT: begin
          cfg_r.variation_limit <= cfg_data;
        end
        pbhm_pkg::CFG_FIXED_AFTER: begin
          cfg_r.fixed_after <= cfg_data[pbhm_pkg::STREAK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: accept and compute power
  pbhm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (q_push),
    .push_data  (q_push_data),
    .queue_full (q_full)
  );

  // decoupling queue
  pbhm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // back: window, judging, per-position state, output register
  pbhm_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .empty     (q_empty),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/pbhm_front.sv
// pbhm_front: accepts input items and computes sample power in two stages
// depends on pbhm_pkg
module pbhm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pbhm_pkg::in_item_t   in_data,
  output logic                 push,
  output pbhm_pkg::work_item_t push_data,
  input  logic                 queue_full
);

  localparam int CUR_PROD_W  = pbhm_pkg::RAW_W + pbhm_pkg::CUR_RECIP_W;
  localparam int VOLT_PROD_W = pbhm_pkg::RAW_W + pbhm_pkg::VOLT_RECIP_W;

  logic                             s1_valid_r;
  logic [pbhm_pkg::POS_W-1:0]       s1_pos_r;
  logic [pbhm_pkg::CURQ_W-1:0]      s1_cur_q_r;
  logic [pbhm_pkg::VOLTQ_W-1:0]     s1_volt_q_r;
  logic                             s2_valid_r;
  pbhm_pkg::work_item_t             s2_r;

  logic [CUR_PROD_W-1:0]            cur_prod;
  logic [VOLT_PROD_W-1:0]           volt_prod;
  logic [pbhm_pkg::POWER_W-1:0]     power_nxt;
  logic                             s1_ready;
  logic                             s2_ready;
  logic                             accept;

  assign cur_prod  = CUR_PROD_W'(in_data.current) * CUR_PROD_W'(pbhm_pkg::CUR_RECIP);
  assign volt_prod = VOLT_PROD_W'(in_data.voltage) * VOLT_PROD_W'(pbhm_pkg::VOLT_RECIP);
  assign power_nxt = pbhm_pkg::POWER_W'(s1_cur_q_r) * pbhm_pkg::POWER_W'(s1_volt_q_r);

  assign s2_ready = !s2_valid_r || !queue_full;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;
  assign push      = s2_valid_r && !queue_full;
  assign push_data = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r    <= in_data.position;
      s1_cur_q_r  <= cur_prod[pbhm_pkg::CUR_SHIFT +: pbhm_pkg::CURQ_W];
      s1_volt_q_r <= volt_prod[pbhm_pkg::VOLT_SHIFT +: pbhm_pkg::VOLTQ_W];
    end
    if (s2_ready && s1_valid_r) begin
      s2_r.position <= s1_pos_r;
      s2_r.power    <= power_nxt;
    end
  end

endmodule

>>> rtl/pbhm_queue.sv
// pbhm_queue: short register queue between front and back
// depends on pbhm_pkg
module pbhm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pbhm_pkg::work_item_t push_data,
  output logic                 full,
  input  logic                 pop,
  output pbhm_pkg::work_item_t pop_data,
  output logic                 empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pbhm_pkg::work_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/pbhm_back.sv
// pbhm_back: power window, settle tracking, band judging and per-position state
// depends on pbhm_pkg
module pbhm_back #(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pbhm_pkg::cfg_t       cfg,
  input  logic                 empty,
  output logic                 pop,
  input  pbhm_pkg::work_item_t pop_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pbhm_pkg::out_item_t  out_data
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int NPOS  = pbhm_pkg::NUM_POSITIONS;

  logic [pbhm_pkg::POWER_W-1:0]  win_r [WINDOW_DEPTH];
  logic [PTR_W-1:0]              ptr_r;
  logic [pbhm_pkg::POS_W-1:0]    prev_pos_r;
  logic [pbhm_pkg::SETTLE_W-1:0] settle_r;
  logic [1:0]                    cond_r [NPOS];
  logic [pbhm_pkg::STREAK_W-1:0] green_r [NPOS];
  logic [pbhm_pkg::STREAK_W-1:0] yellow_r [NPOS];
  logic                          out_valid_r;
  pbhm_pkg::out_item_t           out_r;

  logic [pbhm_pkg::POWER_W-1:0]  win_nxt [WINDOW_DEPTH];
  logic [pbhm_pkg::POWER_W-1:0]  win_hi;
  logic [pbhm_pkg::POWER_W-1:0]  win_lo;
  logic [pbhm_pkg::POWER_W-1:0]  spread;
  logic [PTR_W-1:0]              ptr_nxt;
  logic [pbhm_pkg::SETTLE_W-1:0] settle_nxt;
  logic                          same_pos;
  logic                          judged;
  logic                          in_green;
  logic                          in_yellow;
  logic [1:0]                    cls;
  logic [1:0]                    cond_new;
  logic [pbhm_pkg::STREAK_W-1:0] green_new;
  logic [pbhm_pkg::STREAK_W-1:0] yellow_new;
  logic [1:0]                    cond_upd;
  logic [pbhm_pkg::STREAK_W-1:0] green_upd;
  logic [pbhm_pkg::STREAK_W-1:0] yellow_upd;
  logic [pbhm_pkg::POS_W-1:0]    pos;
  logic [pbhm_pkg::POWER_W-1:0]  power;
  pbhm_pkg::out_item_t           result;

  assign pos       = pop_data.position;
  assign power     = pop_data.power;
  assign pop       = !empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // window with this sample written, then its spread
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_nxt[i] = (PTR_W'(i) == ptr_r) ? power : win_r[i];
    end
    win_hi = win_nxt[0];
    win_lo = win_nxt[0];
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      if (win_nxt[i] > win_hi) begin
        win_hi = win_nxt[i];
      end
      if (win_nxt[i] < win_lo) begin
        win_lo = win_nxt[i];
      end
    end
    spread  = win_hi - win_lo;
    ptr_nxt = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  end

  always_comb begin
    same_pos = (pos == prev_pos_r);
    if (!same_pos) begin
      settle_nxt = '0;
    end else if (settle_r == pbhm_pkg::SETTLE_MAX) begin
      settle_nxt = settle_r;
    end else begin
      settle_nxt = settle_r + 1'b1;
    end
    judged = same_pos && (settle_nxt >= cfg.settle_count) && (spread <= cfg.variation_limit);

    in_green  = (power >= pbhm_pkg::POWER_W'(pbhm_pkg::GREEN_LO[pos])) &&
                (power <  pbhm_pkg::POWER_W'(pbhm_pkg::GREEN_HI[pos]));
    in_yellow = (power >= pbhm_pkg::POWER_W'(pbhm_pkg::YELLOW_LO[pos])) &&
                (power <  pbhm_pkg::POWER_W'(pbhm_pkg::YELLOW_HI[pos]));
    if (!in_yellow) begin
      cls = pbhm_pkg::ST_RED;
    end else if (!in_green) begin
      cls = pbhm_pkg::ST_YELLOW;
    end else begin
      cls = pbhm_pkg::ST_GREEN;
    end

    // saturating streak increments
    green_new  = (green_r[pos] == pbhm_pkg::STREAK_MAX) ? green_r[pos] : green_r[pos] + 1'b1;
    yellow_new = (yellow_r[pos] == pbhm_pkg::STREAK_MAX) ? yellow_r[pos] : yellow_r[pos] + 1'b1;
    cond_new   = cond_r[pos];
    // worse class escalates the state; red resets both streaks, yellow resets the green streak
    if (cls > cond_r[pos]) begin
      if (cls == pbhm_pkg::ST_RED) begin
        green_new  = '0;
        yellow_new = '0;
      end
      if (cls == pbhm_pkg::ST_YELLOW) begin
        green_new = '0;
      end
      cond_new = cls;
    end
    // long streaks pull the state back down
    if (yellow_new > cfg.fixed_after) begin
      cond_new = pbhm_pkg::ST_YELLOW;
    end
    if (green_new > cfg.fixed_after) begin
      cond_new = pbhm_pkg::ST_GREEN;
    end

    cond_upd   = judged ? cond_new   : cond_r[pos];
    green_upd  = judged ? green_new  : green_r[pos];
    yellow_upd = judged ? yellow_new : yellow_r[pos];

    result.power          = power;
    result.judged         = judged;
    result.sample_class   = judged ? cls : pbhm_pkg::ST_WHITE;
    result.position_state = cond_upd;
    result.green_count    = green_upd;
    result.yellow_count   = yellow_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      for (int i = 0; i < NPOS; i++) begin
        cond_r[i]   <= pbhm_pkg::ST_WHITE;
        green_r[i]  <= '0;
        yellow_r[i] <= '0;
      end
      ptr_r       <= '0;
      prev_pos_r  <= '0;
      settle_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          win_r[i] <= win_nxt[i];
        end
        ptr_r         <= ptr_nxt;
        prev_pos_r    <= pos;
        settle_r      <= settle_nxt;
        cond_r[pos]   <= cond_upd;
        green_r[pos]  <= green_upd;
        yellow_r[pos] <= yellow_upd;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= result;
    end
  end

  a_judged_has_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.judged |-> out_r.sample_class != pbhm_pkg::ST_WHITE)
    else $error("judged item without a class");

  a_unjudged_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.judged |-> out_r.sample_class == pbhm_pkg::ST_WHITE)
    else $error("unjudged item carries a class");

  a_judged_leaves_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.judged |-> out_r.position_state != pbhm_pkg::ST_WHITE)
    else $error("judged position still white");

  a_new_pos_not_judged: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (pop_data.position != prev_pos_r) |=> !out_r.judged)
    else $error("item judged on a position change");

endmodule
